>>> rtl/core/searchable_lifo_stack_top_assert.svh
// Assertion macros for the searchable LIFO stack top level.
`ifndef SEARCHABLE_LIFO_STACK_TOP_ASSERT_SVH
`define SEARCHABLE_LIFO_STACK_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SLS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sls_pkg.sv
// Package with the types and constants of the searchable LIFO stack.
package sls_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int WORD_W        = 32;

    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_PEEK   = 3'd2,
        OP_READ   = 3'd3,
        OP_SEARCH = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADINDEX = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic [2:0]               op;
        logic signed [WORD_W-1:0] value;
        logic [2:0]               index;
    } req_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [WORD_W-1:0] data;
        logic [2:0]               position;
        logic [3:0]               fill;
    } rsp_t;

endpackage

>>> rtl/core/sls_mem.sv
// Single-port-write, registered-read memory holding the stack entries.
module sls_mem #(
    parameter int DEPTH = sls_pkg::DEPTH_DEFAULT,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [sls_pkg::WORD_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [sls_pkg::WORD_W-1:0] rd_data
);

    logic [sls_pkg::WORD_W-1:0] mem [DEPTH];
    logic [sls_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/sls_seq.sv
// Sequencer that runs one stack transaction at a time against the entry memory.
module sls_seq #(
    parameter int DEPTH = sls_pkg::DEPTH_DEFAULT,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  sls_pkg::req_t              req,
    output logic                       res_valid,
    input  logic                       res_ready,
    output sls_pkg::rsp_t              res,
    output logic                       wr_en,
    output logic [AW-1:0]              wr_addr,
    output logic [sls_pkg::WORD_W-1:0] wr_data,
    output logic                       rd_en,
    output logic [AW-1:0]              rd_addr,
    input  logic [sls_pkg::WORD_W-1:0] rd_data
);

    localparam int IXW = (CW > 3) ? CW : 3;

    sls_pkg::seq_state_t        state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [AW-1:0]              ptr_reg, ptr_next;
    logic [sls_pkg::WORD_W-1:0] value_reg, value_next;
    sls_pkg::rsp_t              res_reg, res_next;
    logic                       empty;
    logic                       full;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sls_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        value_reg <= value_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        value_next = value_reg;
        res_next   = res_reg;
        req_ready  = 1'b0;
        res_valid  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = count_reg[AW-1:0];
        wr_data    = req.value;
        rd_en      = 1'b0;
        rd_addr    = ptr_reg;

        unique case (state_reg)
            sls_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    value_next        = req.value;
                    res_next.status   = sls_pkg::ST_OK;
                    res_next.data     = '0;
                    res_next.position = '0;
                    res_next.fill     = 4'(count_reg);
                    state_next        = sls_pkg::S_DONE;
                    unique case (req.op)
                        sls_pkg::OP_PUSH:
                        begin
                            if (full)
                            begin
                                res_next.status = sls_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                count_next    = count_reg + CW'(1);
                                res_next.data = req.value;
                                res_next.fill = 4'(count_reg + CW'(1));
                            end
                        end
                        sls_pkg::OP_POP:
                        begin
                            if (empty)
                            begin
                                res_next.status = sls_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rd_en         = 1'b1;
                                rd_addr       = AW'(count_reg - CW'(1));
                                count_next    = count_reg - CW'(1);
                                res_next.fill = 4'(count_reg - CW'(1));
                                state_next    = sls_pkg::S_READ;
                            end
                        end
                        sls_pkg::OP_PEEK:
                        begin
                            if (empty)
                            begin
                                res_next.status = sls_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(count_reg - CW'(1));
                                state_next = sls_pkg::S_READ;
                            end
                        end
                        sls_pkg::OP_READ:
                        begin
                            if (empty)
                            begin
                                res_next.status = sls_pkg::ST_EMPTY;
                            end
                            else if (IXW'(req.index) >= IXW'(count_reg))
                            begin
                                res_next.status = sls_pkg::ST_BADINDEX;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(req.index);
                                state_next = sls_pkg::S_READ;
                            end
                        end
                        sls_pkg::OP_SEARCH:
                        begin
                            if (empty)
                            begin
                                res_next.status = sls_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                ptr_next   = '0;
                                state_next = sls_pkg::S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            sls_pkg::S_READ:
            begin
                res_next.data = rd_data;
                state_next    = sls_pkg::S_DONE;
            end
            sls_pkg::S_SCAN:
            begin
                if (rd_data == value_reg)
                begin
                    res_next.position = 3'(ptr_reg);
                    state_next        = sls_pkg::S_DONE;
                end
                else if (CW'(ptr_reg) + CW'(1) == count_reg)
                begin
                    res_next.status = sls_pkg::ST_NOTFOUND;
                    state_next      = sls_pkg::S_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg + AW'(1);
                end
            end
            sls_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = sls_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sls_pkg::S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

endmodule

>>> rtl/core/searchable_lifo_stack_top.sv
// Top level of the searchable LIFO stack with its output register.
//
// Requests arrive on the req channel (valid/ready) and carry an operation:
// push, pop, peek at the top, read at an index, or search for a value. Every
// request transaction yields exactly one response transaction on the rsp
// channel (valid/ready) with a status, the word concerned, the matching
// position for a search and the fill level after the operation.
// One request is processed at a time by a sequencer working against a
// memory with a registered read. From acceptance a push, an operation
// refused at once or an operation with no meaning goes straight to S_DONE;
// a pop, peek or read first waits in S_READ for the memory word, and a
// search scans the entries from the bottom in S_SCAN until it finds a match
// or reaches the fill level. The next request is accepted in the cycle after
// the result leaves the sequencer; the search scan, one entry per memory
// read, sets the worst case spacing between requests.
// Reset empties the stack at once; the entries themselves are not cleared.
// When the receiver stalls, one finished response waits in the output
// register while the sequencer goes on with the next request, and it holds
// its own result until the output register is free again.
module searchable_lifo_stack_top #(
    parameter int DEPTH = sls_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  sls_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output sls_pkg::rsp_t rsp
);

    localparam int AW = $clog2(DEPTH);

    logic                       res_valid;
    logic                       res_ready;
    sls_pkg::rsp_t              res;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [sls_pkg::WORD_W-1:0] wr_data;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [sls_pkg::WORD_W-1:0] rd_data;
    logic                       rsp_valid_reg, rsp_valid_next;
    sls_pkg::rsp_t              rsp_reg, rsp_next;

    sls_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    sls_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (res_ready)
        begin
            rsp_valid_next = res_valid;
            if (res_valid)
            begin
                rsp_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`include "searchable_lifo_stack_top_assert.svh"

    `SLS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")
    `SLS_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid && $stable(res), "result lost")
    `SLS_ASSERT_NOW(a_fail_no_data, rsp_valid && rsp.status != sls_pkg::ST_OK, rsp.data == '0, "failed transaction carries data")
    `SLS_ASSERT_NOW(a_pos_only_ok, rsp_valid && rsp.position != '0, rsp.status == sls_pkg::ST_OK, "position on failed transaction")

endmodule

>>> bench/sls_result_monitor.sv
// Monitor that predicts and checks every response of the searchable LIFO stack.
module sls_result_monitor #(
    parameter int DEPTH = sls_pkg::DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  sls_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  sls_pkg::rsp_t rsp,
    output int            error_count,
    output int            results_owed
);

    logic [31:0]   stack_words [DEPTH];
    int            held;
    int            fails;
    sls_pkg::rsp_t owed_q [$];

    function automatic sls_pkg::rsp_t apply_stack_op(input sls_pkg::req_t r);
        sls_pkg::rsp_t res;
        res = '0;
        case (r.op)
            sls_pkg::OP_PUSH:
            begin
                if (held >= DEPTH)
                    res.status = sls_pkg::ST_FULL;
                else
                begin
                    stack_words[held] = r.value;
                    held++;
                    res.data = r.value;
                end
            end
            sls_pkg::OP_POP:
            begin
                if (held == 0)
                    res.status = sls_pkg::ST_EMPTY;
                else
                begin
                    held--;
                    res.data = stack_words[held];
                end
            end
            sls_pkg::OP_PEEK:
            begin
                if (held == 0)
                    res.status = sls_pkg::ST_EMPTY;
                else
                    res.data = stack_words[held - 1];
            end
            sls_pkg::OP_READ:
            begin
                if (held == 0)
                    res.status = sls_pkg::ST_EMPTY;
                else if (int'(r.index) >= held)
                    res.status = sls_pkg::ST_BADINDEX;
                else
                    res.data = stack_words[r.index];
            end
            sls_pkg::OP_SEARCH:
            begin
                // Scanning downwards leaves the lowest matching entry in place.
                res.status = sls_pkg::ST_NOTFOUND;
                for (int i = DEPTH - 1; i >= 0; i--)
                begin
                    if (i < held && stack_words[i] == r.value)
                    begin
                        res.status   = sls_pkg::ST_OK;
                        res.position = 3'(i);
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.fill = 4'(held);
        return res;
    endfunction

    task automatic report_fault(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        fails++;
        if (fails <= 10)
            $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sls_pkg::rsp_t want;
        if (!rst_n)
        begin
            held = 0;
            fails = 0;
            owed_q.delete();
            error_count  <= 0;
            results_owed <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
                owed_q.push_back(apply_stack_op(req));
            if (rsp_valid && rsp_ready)
            begin
                if (owed_q.size() == 0)
                    report_fault("response with none outstanding", '0, rsp.data);
                else
                begin
                    want = owed_q.pop_front();
                    if (rsp.status !== want.status)
                        report_fault("status", want.status, rsp.status);
                    if (rsp.data !== want.data)
                        report_fault("data", want.data, rsp.data);
                    if (rsp.position !== want.position)
                        report_fault("position", want.position, rsp.position);
                    if (rsp.fill !== want.fill)
                        report_fault("fill", want.fill, rsp.fill);
                end
            end
            error_count  <= fails;
            results_owed <= owed_q.size();
        end
    end

endmodule

>>> bench/tb_searchable_lifo_stack_top.sv
// Testbench top that drives the searchable LIFO stack and gives the verdict.
module tb_searchable_lifo_stack_top;

    localparam int DEPTH        = sls_pkg::DEPTH_DEFAULT;
    localparam int IDLE_LIMIT   = 1000;
    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_ITEMS = 650;
    localparam int SETTLE       = 20;

    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    sls_pkg::req_t req       = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    sls_pkg::rsp_t rsp;

    int error_count;
    int results_owed;
    int idle_cycles     = 0;
    bit steady          = 1'b0;
    bit hold_off_wanted = 1'b0;

    searchable_lifo_stack_top #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    sls_result_monitor #(.DEPTH(DEPTH)) result_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp),
        .error_count  (error_count),
        .results_owed (results_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0, 1:    return $urandom;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h8000_0000;
            5:       return 32'h7FFF_FFFF;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [31:0] value,
                             input logic [2:0] index);
        int gap;
        req_valid <= 1'b1;
        req.op    <= op;
        req.value <= value;
        req.index <= index;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    // Receiver: ready runs and gaps of random length, with one long hold-off on request.
    initial
    begin
        int run;
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_wanted)
            begin
                hold_off_wanted = 1'b0;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 8);
                rsp_ready <= 1'b1;
                repeat (run) @(posedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    rsp_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int          lean;
        int          roll;
        int          push_pct;
        int          pop_pct;
        logic [2:0]  op;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty stack first, then fill to the limit and past it.
        send_item(sls_pkg::OP_POP,    32'h0000_0000, 3'd0);
        send_item(sls_pkg::OP_PEEK,   32'h0000_0000, 3'd0);
        send_item(sls_pkg::OP_READ,   32'h0000_0000, 3'd0);
        send_item(sls_pkg::OP_SEARCH, 32'h0000_0000, 3'd0);
        send_item(OP_SPARE_LO,        32'hFFFF_FFFF, 3'd7);
        send_item(sls_pkg::OP_PUSH,   32'h8000_0000, 3'd0);
        send_item(sls_pkg::OP_PUSH,   32'h7FFF_FFFF, 3'd7);
        send_item(sls_pkg::OP_PUSH,   32'hFFFF_FFFF, 3'd0);
        send_item(sls_pkg::OP_PUSH,   32'h0000_0000, 3'd0);
        send_item(sls_pkg::OP_PUSH,   32'h7FFF_FFFF, 3'd0);
        send_item(sls_pkg::OP_READ,   32'h0000_0000, 3'd5);
        send_item(sls_pkg::OP_SEARCH, 32'h7FFF_FFFF, 3'd0);
        send_item(sls_pkg::OP_PUSH,   32'h5555_5555, 3'd0);
        send_item(sls_pkg::OP_PUSH,   32'hAAAA_AAAA, 3'd0);
        send_item(sls_pkg::OP_PUSH,   32'h0000_0001, 3'd0);
        send_item(sls_pkg::OP_PUSH,   32'h0000_0002, 3'd0);
        send_item(sls_pkg::OP_READ,   32'h0000_0000, 3'd7);
        send_item(sls_pkg::OP_PEEK,   32'h0000_0000, 3'd2);
        send_item(sls_pkg::OP_SEARCH, 32'h0000_0001, 3'd0);
        send_item(sls_pkg::OP_SEARCH, 32'h0001_2345, 3'd0);
        send_item(OP_SPARE_MID,       32'h0000_0000, 3'd0);
        send_item(OP_SPARE_HI,        32'h1234_5678, 3'd3);
        send_item(sls_pkg::OP_POP,    32'h0000_0000, 3'd0);
        send_item(sls_pkg::OP_POP,    32'h0000_0000, 3'd0);

        lean = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                lean   = $urandom_range(0, 2);
                steady = ($urandom_range(0, 3) == 0);
            end
            if (n == 150 || n == 420)
                hold_off_wanted = 1'b1;
            if (n == 300)
                wait_drained();
            push_pct = (lean == 1) ? 55 : (lean == 2) ? 15 : 30;
            pop_pct  = (lean == 2) ? 45 : 15;
            roll     = $urandom_range(0, 99);
            if (roll < push_pct)
                op = sls_pkg::OP_PUSH;
            else if (roll < push_pct + pop_pct)
                op = sls_pkg::OP_POP;
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1:       op = sls_pkg::OP_PEEK;
                    2, 3, 4:    op = sls_pkg::OP_READ;
                    5, 6, 7, 8: op = sls_pkg::OP_SEARCH;
                    default:
                    begin
                        case ($urandom_range(0, 2))
                            0:       op = OP_SPARE_LO;
                            1:       op = OP_SPARE_MID;
                            default: op = OP_SPARE_HI;
                        endcase
                    end
                endcase
            end
            send_item(op, pick_word(), 3'($urandom_range(0, 7)));
        end

        steady = 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (error_count == 0 && results_owed == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
